@@ rtl/mbrr_pkg.sv @@
package mbrr_pkg;

    localparam logic [7:0]  ADDR_RESET        = 8'h01;
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  EXPECTED_COUNT    = 8'h02;
    localparam logic [7:0]  START_ADDR_HI     = 8'h00;
    localparam logic [7:0]  START_ADDR_LO     = 8'h00;
    localparam logic [7:0]  REG_COUNT_HI      = 8'h00;
    localparam logic [7:0]  REG_COUNT_LO      = 8'h01;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;

    localparam logic MODE_START    = 1'b0;
    localparam logic MODE_RESPONSE = 1'b1;

    localparam logic KIND_TX      = 1'b0;
    localparam logic KIND_READING = 1'b1;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_HEADER = 2'd1;
    localparam logic [1:0] STATUS_BAD_CRC    = 2'd2;

    // Positions in the request frame.
    localparam logic [2:0] TX_POS_ADDR     = 3'd0;
    localparam logic [2:0] TX_POS_FUNC     = 3'd1;
    localparam logic [2:0] TX_POS_START_HI = 3'd2;
    localparam logic [2:0] TX_POS_START_LO = 3'd3;
    localparam logic [2:0] TX_POS_COUNT_HI = 3'd4;
    localparam logic [2:0] TX_POS_COUNT_LO = 3'd5;
    localparam logic [2:0] TX_POS_CRC_LO   = 3'd6;
    localparam logic [2:0] TX_POS_CRC_HI   = 3'd7;

    // Positions in the response frame.
    localparam logic [2:0] RX_POS_ADDR   = 3'd0;
    localparam logic [2:0] RX_POS_FUNC   = 3'd1;
    localparam logic [2:0] RX_POS_COUNT  = 3'd2;
    localparam logic [2:0] RX_POS_VAL_HI = 3'd3;
    localparam logic [2:0] RX_POS_VAL_LO = 3'd4;
    localparam logic [2:0] RX_POS_CRC_LO = 3'd5;
    localparam logic [2:0] RX_POS_CRC_HI = 3'd6;

    typedef struct packed {
        logic        final_byte;
        logic [15:0] reading;
        logic [1:0]  status;
    } rx_result_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/mbrr_rx_frame.sv @@
module mbrr_rx_frame
    import mbrr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       clear,
    input  logic       byte_valid,
    input  logic [7:0] rx_byte,
    input  logic [7:0] expected_addr,
    output rx_result_t result
);

    logic [2:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic        hdr_good_reg, hdr_good_next;
    logic [7:0]  val_hi_reg, val_hi_next;
    logic [7:0]  val_lo_reg, val_lo_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic [15:0] rx_crc;

    always_comb begin
        idx_next      = idx_reg;
        crc_next      = crc_reg;
        hdr_good_next = hdr_good_reg;
        val_hi_next   = val_hi_reg;
        val_lo_next   = val_lo_reg;
        crc_lo_next   = crc_lo_reg;
        if (clear || (byte_valid && idx_reg == RX_POS_CRC_HI)) begin
            idx_next      = RX_POS_ADDR;
            crc_next      = CRC_INIT;
            hdr_good_next = 1'b1;
            val_hi_next   = 8'h00;
            val_lo_next   = 8'h00;
            crc_lo_next   = 8'h00;
        end else if (byte_valid) begin
            idx_next = idx_reg + 3'd1;
            if (idx_reg < RX_POS_CRC_LO) begin
                crc_next = crc_feed(crc_reg, rx_byte);
            end
            case (idx_reg)
                RX_POS_ADDR: begin
                    if (rx_byte != expected_addr) hdr_good_next = 1'b0;
                end
                RX_POS_FUNC: begin
                    if (rx_byte != FUNC_READ_HOLDING) hdr_good_next = 1'b0;
                end
                RX_POS_COUNT: begin
                    if (rx_byte != EXPECTED_COUNT) hdr_good_next = 1'b0;
                end
                RX_POS_VAL_HI: val_hi_next = rx_byte;
                RX_POS_VAL_LO: val_lo_next = rx_byte;
                RX_POS_CRC_LO: crc_lo_next = rx_byte;
                default: ;
            endcase
        end
    end

    // The reading is resolved from the stored bytes and the final CRC byte on the wire.
    assign rx_crc = {rx_byte, crc_lo_reg};

    always_comb begin
        result.final_byte = (idx_reg == RX_POS_CRC_HI);
        result.reading    = 16'h0000;
        if (!hdr_good_reg) begin
            result.status = STATUS_BAD_HEADER;
        end else if (rx_crc != crc_reg) begin
            result.status = STATUS_BAD_CRC;
        end else begin
            result.status  = STATUS_OK;
            result.reading = {val_hi_reg, val_lo_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= RX_POS_ADDR;
            crc_reg      <= CRC_INIT;
            hdr_good_reg <= 1'b1;
            val_hi_reg   <= 8'h00;
            val_lo_reg   <= 8'h00;
            crc_lo_reg   <= 8'h00;
        end else begin
            idx_reg      <= idx_next;
            crc_reg      <= crc_next;
            hdr_good_reg <= hdr_good_next;
            val_hi_reg   <= val_hi_next;
            val_lo_reg   <= val_lo_next;
            crc_lo_reg   <= crc_lo_next;
        end
    end

endmodule

@@ rtl/modbus_read_register_frame_engine_core.sv @@
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_mode, s_rx_byte
// m_        out        m_valid / m_ready  m_kind, m_tx_byte, m_last, m_reading, m_status
// cfg_      in         cfg_we             cfg_wdata (slave address)
//
// A response byte leaves s_ready high, so the next item can be accepted in the following cycle
// unless the stall described below holds it. A start item holds s_ready low while the request
// sequencer loads one frame byte per cycle into the output register whenever that register is free,
// folding each byte ahead of the CRC into the request CRC. Reset is synchronous on aresetn; the
// slave address returns to 1. A stalled m_ready holds s_ready low only for the final reply byte
// when the output register is full and not being drained, or while it holds back a request going out.
module modbus_read_register_frame_engine_core
    import mbrr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_tx_byte,
    output logic        m_last,
    output logic [15:0] m_reading,
    output logic [1:0]  m_status
);

    logic [7:0]  dev_addr_reg;
    logic        tx_active_reg, tx_active_next;
    logic [2:0]  tx_idx_reg, tx_idx_next;
    logic [15:0] tx_crc_reg, tx_crc_next;

    logic        m_valid_reg, m_valid_next;
    logic        m_kind_reg, m_kind_next;
    logic [7:0]  m_tx_byte_reg, m_tx_byte_next;
    logic        m_last_reg, m_last_next;
    logic [15:0] m_reading_reg, m_reading_next;
    logic [1:0]  m_status_reg, m_status_next;

    logic        out_free;
    logic        s_fire;
    logic        start_fire;
    logic        rx_fire;
    logic        load_tx;
    logic        load_rd;
    logic [7:0]  frame_byte;
    rx_result_t  rx_res;

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = !tx_active_reg
                        && (out_free || s_mode == MODE_START || !rx_res.final_byte);
    assign s_fire     = s_valid && s_ready;
    assign start_fire = s_fire && s_mode == MODE_START;
    assign rx_fire    = s_fire && s_mode == MODE_RESPONSE;
    assign load_tx    = tx_active_reg && out_free;
    assign load_rd    = rx_fire && rx_res.final_byte;

    mbrr_rx_frame u_rx_frame (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .clear         (start_fire),
        .byte_valid    (rx_fire),
        .rx_byte       (s_rx_byte),
        .expected_addr (dev_addr_reg),
        .result        (rx_res)
    );

    always_comb begin
        case (tx_idx_reg)
            TX_POS_ADDR:     frame_byte = dev_addr_reg;
            TX_POS_FUNC:     frame_byte = FUNC_READ_HOLDING;
            TX_POS_START_HI: frame_byte = START_ADDR_HI;
            TX_POS_START_LO: frame_byte = START_ADDR_LO;
            TX_POS_COUNT_HI: frame_byte = REG_COUNT_HI;
            TX_POS_COUNT_LO: frame_byte = REG_COUNT_LO;
            TX_POS_CRC_LO:   frame_byte = tx_crc_reg[7:0];
            TX_POS_CRC_HI:   frame_byte = tx_crc_reg[15:8];
            default:         frame_byte = 8'h00;
        endcase
    end

    always_comb begin
        tx_active_next = tx_active_reg;
        tx_idx_next    = tx_idx_reg;
        tx_crc_next    = tx_crc_reg;
        if (start_fire) begin
            tx_active_next = 1'b1;
            tx_idx_next    = TX_POS_ADDR;
            tx_crc_next    = CRC_INIT;
        end else if (load_tx) begin
            tx_idx_next = tx_idx_reg + 3'd1;
            if (tx_idx_reg < TX_POS_CRC_LO) begin
                tx_crc_next = crc_feed(tx_crc_reg, frame_byte);
            end
            if (tx_idx_reg == TX_POS_CRC_HI) begin
                tx_active_next = 1'b0;
            end
        end
    end

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_kind_next    = m_kind_reg;
        m_tx_byte_next = m_tx_byte_reg;
        m_last_next    = m_last_reg;
        m_reading_next = m_reading_reg;
        m_status_next  = m_status_reg;
        if (load_tx) begin
            m_valid_next   = 1'b1;
            m_kind_next    = KIND_TX;
            m_tx_byte_next = frame_byte;
            m_last_next    = (tx_idx_reg == TX_POS_CRC_HI);
            m_reading_next = 16'h0000;
            m_status_next  = STATUS_OK;
        end else if (load_rd) begin
            m_valid_next   = 1'b1;
            m_kind_next    = KIND_READING;
            m_tx_byte_next = 8'h00;
            m_last_next    = 1'b1;
            m_reading_next = rx_res.reading;
            m_status_next  = rx_res.status;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg  <= ADDR_RESET;
            tx_active_reg <= 1'b0;
            tx_idx_reg    <= TX_POS_ADDR;
            tx_crc_reg    <= CRC_INIT;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                dev_addr_reg <= cfg_wdata;
            end
            tx_active_reg <= tx_active_next;
            tx_idx_reg    <= tx_idx_next;
            tx_crc_reg    <= tx_crc_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_kind_reg    <= m_kind_next;
        m_tx_byte_reg <= m_tx_byte_next;
        m_last_reg    <= m_last_next;
        m_reading_reg <= m_reading_next;
        m_status_reg  <= m_status_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_kind    = m_kind_reg;
    assign m_tx_byte = m_tx_byte_reg;
    assign m_last    = m_last_reg;
    assign m_reading = m_reading_reg;
    assign m_status  = m_status_reg;

endmodule

@@ rtl/mbrr_checker.sv @@
module mbrr_checker
    import mbrr_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_mode,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_kind,
    input logic [7:0]  m_tx_byte,
    input logic        m_last,
    input logic [15:0] m_reading,
    input logic [1:0]  m_status
);

    // A start item keeps the input side closed while its request goes out.
    a_start_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode == MODE_START |=> !s_ready)
        else $error("input accepted right after a start item");

    // Request bytes follow each other without a gap until the last one.
    a_tx_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_kind == KIND_TX && !m_last |=> m_valid && m_kind == KIND_TX)
        else $error("request frame interrupted");

    // A reading closes its item and carries a value only when it is good.
    a_reading_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_READING |-> m_last
            && (m_status == STATUS_OK || m_reading == 16'h0000))
        else $error("malformed reading item");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_byte) && $stable(m_kind)
            && $stable(m_reading) && $stable(m_status) && $stable(m_last))
        else $error("stalled result item changed");

endmodule

bind modbus_read_register_frame_engine_core mbrr_checker u_mbrr_checker (.*);

@@ sim/modbus_read_register_frame_engine_core_chk.sv @@
module modbus_read_register_frame_engine_core_chk
    import mbrr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_kind,
    input  logic [7:0]  m_tx_byte,
    input  logic        m_last,
    input  logic [15:0] m_reading,
    input  logic [1:0]  m_status,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // One output word: either a request byte or a finished register reading.
    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [15:0] reading;
        logic [1:0]  status;
    } mb_word_t;

    mb_word_t    owed_words[$];
    int          bad_count = 0;

    logic [7:0]  dev_addr;
    logic [2:0]  rx_pos;
    logic [15:0] rx_crc;
    logic        hdr_ok;
    logic [7:0]  val_hi;
    logic [7:0]  val_lo;
    logic [7:0]  crc_lo_rx;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc,
                                                      input logic [7:0] data);
        logic [15:0] r;
        r = crc ^ {8'h00, data};
        repeat (8) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic void clear_rx();
        rx_pos    = RX_POS_ADDR;
        rx_crc    = CRC_INIT;
        hdr_ok    = 1'b1;
        val_hi    = 8'h00;
        val_lo    = 8'h00;
        crc_lo_rx = 8'h00;
    endfunction

    function automatic void model_modbus_item(input logic mode, input logic [7:0] data);
        logic [7:0]  frame [0:7];
        logic [15:0] crc;
        mb_word_t    w;
        if (mode == MODE_START) begin
            clear_rx();
            frame[TX_POS_ADDR]     = dev_addr;
            frame[TX_POS_FUNC]     = FUNC_READ_HOLDING;
            frame[TX_POS_START_HI] = START_ADDR_HI;
            frame[TX_POS_START_LO] = START_ADDR_LO;
            frame[TX_POS_COUNT_HI] = REG_COUNT_HI;
            frame[TX_POS_COUNT_LO] = REG_COUNT_LO;
            crc = CRC_INIT;
            for (int i = 0; i < 6; i++) begin
                crc = crc16_modbus_byte(crc, frame[i]);
            end
            frame[TX_POS_CRC_LO] = crc[7:0];
            frame[TX_POS_CRC_HI] = crc[15:8];
            for (int i = 0; i < 8; i++) begin
                w.kind    = KIND_TX;
                w.tx_byte = frame[i];
                w.last    = (i == 7);
                w.reading = 16'h0000;
                w.status  = STATUS_OK;
                owed_words.insert(owed_words.size(), w);
            end
            return;
        end
        case (rx_pos)
            RX_POS_ADDR:   if (data != dev_addr) hdr_ok = 1'b0;
            RX_POS_FUNC:   if (data != FUNC_READ_HOLDING) hdr_ok = 1'b0;
            RX_POS_COUNT:  if (data != EXPECTED_COUNT) hdr_ok = 1'b0;
            RX_POS_VAL_HI: val_hi = data;
            RX_POS_VAL_LO: val_lo = data;
            RX_POS_CRC_LO: crc_lo_rx = data;
            default: begin
                w.kind    = KIND_READING;
                w.tx_byte = 8'h00;
                w.last    = 1'b1;
                w.reading = 16'h0000;
                // A bad header wins over a bad CRC.
                if (!hdr_ok) begin
                    w.status = STATUS_BAD_HEADER;
                end else if ({data, crc_lo_rx} != rx_crc) begin
                    w.status = STATUS_BAD_CRC;
                end else begin
                    w.status  = STATUS_OK;
                    w.reading = {val_hi, val_lo};
                end
                owed_words.insert(owed_words.size(), w);
                clear_rx();
                return;
            end
        endcase
        if (rx_pos < RX_POS_CRC_LO) begin
            rx_crc = crc16_modbus_byte(rx_crc, data);
        end
        rx_pos = rx_pos + 3'd1;
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            bad_count++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        mb_word_t want;
        if (!aresetn) begin
            dev_addr = ADDR_RESET;
            clear_rx();
            owed_words.delete();
        end else begin
            if (cfg_we) begin
                dev_addr = cfg_wdata;
            end
            if (s_valid && s_ready) begin
                model_modbus_item(s_mode, s_rx_byte);
            end
            if (m_valid && m_ready) begin
                if (owed_words.size() == 0) begin
                    $error("output item with nothing expected: kind %0d tx_byte 0x%0h",
                           m_kind, m_tx_byte);
                    bad_count++;
                end else begin
                    want = owed_words.pop_front();
                    compare_field("kind", 16'(want.kind), 16'(m_kind));
                    compare_field("tx_byte", 16'(want.tx_byte), 16'(m_tx_byte));
                    compare_field("last", 16'(want.last), 16'(m_last));
                    compare_field("reading", want.reading, m_reading);
                    compare_field("status", 16'(want.status), 16'(m_status));
                end
            end
        end
        outstanding <= owed_words.size();
        mismatches  <= bad_count;
    end

endmodule

@@ sim/modbus_read_register_frame_engine_core_tb.sv @@
module modbus_read_register_frame_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mbrr_pkg::*;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_valid   = 1'b0;
    logic        s_mode    = 1'b0;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_ready   = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_kind;
    logic [7:0]  m_tx_byte;
    logic        m_last;
    logic [15:0] m_reading;
    logic [1:0]  m_status;

    int          mismatches;
    int          outstanding;
    bit          idle_on    = 1'b1;
    int          stall_left = 0;
    int          n_sent     = 0;
    logic [7:0]  addr_now   = ADDR_RESET;

    modbus_read_register_frame_engine_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .s_rx_byte (s_rx_byte),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_kind    (m_kind),
        .m_tx_byte (m_tx_byte),
        .m_last    (m_last),
        .m_reading (m_reading),
        .m_status  (m_status)
    );

    modbus_read_register_frame_engine_core_chk u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_rx_byte   (s_rx_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_tx_byte   (m_tx_byte),
        .m_last      (m_last),
        .m_reading   (m_reading),
        .m_status    (m_status),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side back-pressure, in bursts.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Presents one item and returns right after the edge that accepts it.
    task automatic send(input logic mode, input logic [7:0] data);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid   <= 1'b0;
            s_mode    <= 1'($urandom);
            s_rx_byte <= 8'($urandom);
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_mode    <= mode;
        s_rx_byte <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
    endtask

    task automatic send_reply(input logic [7:0] addr, input logic [7:0] func,
                              input logic [7:0] cnt, input logic [15:0] value,
                              input logic [15:0] crc_flip);
        logic [7:0]  fr [0:6];
        logic [15:0] crc;
        fr[0] = addr;
        fr[1] = func;
        fr[2] = cnt;
        fr[3] = value[15:8];
        fr[4] = value[7:0];
        crc = CRC_INIT;
        for (int i = 0; i < 5; i++) begin
            crc = crc_feed(crc, fr[i]);
        end
        crc   = crc ^ crc_flip;
        fr[5] = crc[7:0];
        fr[6] = crc[15:8];
        foreach (fr[i]) begin
            send(MODE_RESPONSE, fr[i]);
        end
    endtask

    // Drops valid and waits until every expected item has come out, then waits on for
    // bytes that cause no item, which may still be in flight.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_dev_addr(input logic [7:0] value);
        settle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        addr_now = value;
    endtask

    task automatic random_sequence();
        int          sel;
        int          n;
        logic [15:0] value;
        sel   = $urandom_range(0, 19);
        value = 16'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        if (sel < 3) begin
            send(MODE_START, 8'($urandom));
        end else if (sel < 13) begin
            send_reply(addr_now, FUNC_READ_HOLDING, EXPECTED_COUNT, value, 16'h0000);
        end else if (sel < 16) begin
            case ($urandom_range(0, 4))
                0: send_reply(addr_now ^ 8'($urandom_range(1, 255)), FUNC_READ_HOLDING,
                              EXPECTED_COUNT, value, 16'h0000);
                1: send_reply(addr_now, FUNC_READ_HOLDING ^ 8'($urandom_range(1, 255)),
                              EXPECTED_COUNT, value, 16'h0000);
                2: send_reply(addr_now, FUNC_READ_HOLDING,
                              EXPECTED_COUNT ^ 8'($urandom_range(1, 255)), value, 16'h0000);
                3: send_reply(addr_now, FUNC_READ_HOLDING, EXPECTED_COUNT, value,
                              16'($urandom_range(1, 65535)));
                default: send_reply(addr_now ^ 8'($urandom_range(1, 255)),
                                    FUNC_READ_HOLDING, EXPECTED_COUNT, value,
                                    16'($urandom_range(1, 65535)));
            endcase
        end else if (sel < 18) begin
            // A cut-off reply, often followed by a fresh request that realigns framing.
            n = $urandom_range(1, 6);
            repeat (n) send(MODE_RESPONSE, 8'($urandom));
            if ($urandom_range(0, 1) == 1) begin
                send(MODE_START, 8'($urandom));
            end
        end else begin
            send(1'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: request, clean reply at full scale, reply bad in both header and
        // CRC, a reply cut off by a new request, then a clean reply of zero.
        send(MODE_START, 8'hA5);
        send_reply(addr_now, FUNC_READ_HOLDING, EXPECTED_COUNT, 16'hFFFF, 16'h0000);
        send_reply(~addr_now, 8'h04, 8'h00, 16'h1234, 16'h0001);
        send(MODE_RESPONSE, addr_now);
        send(MODE_RESPONSE, FUNC_READ_HOLDING);
        send(MODE_RESPONSE, EXPECTED_COUNT);
        send(MODE_START, 8'h00);
        send_reply(addr_now, FUNC_READ_HOLDING, EXPECTED_COUNT, 16'h0000, 16'h0000);

        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       write_dev_addr(8'h00);
                1:       write_dev_addr(8'hFF);
                4:       write_dev_addr(ADDR_RESET);
                default: write_dev_addr(8'($urandom));
            endcase
            while (n_sent < 26 + (p + 1) * 64) begin
                idle_on = (p < 5) && ($urandom_range(0, 4) != 0);
                random_sequence();
            end
        end

        settle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
